>>> rtl/bdes_pkg.sv
// Shared types, constants and helpers for the debounced button event scanner.
// Used by every module under rtl/; depends on nothing else.
package bdes_pkg;

	// Port and field widths fixed by the interface
	localparam int unsigned PORT_W       = 8;
	localparam int unsigned IDX_W        = 3;
	localparam int unsigned TICK_W       = 9;
	localparam int unsigned NUM_BUTTONS_DEF = 8;

	// Event code parts
	localparam logic [7:0] CODE_BASE    = 8'h20;
	localparam logic [7:0] CODE_RELEASE = 8'h80;

	// Scan queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Input kinds
	localparam logic CMD_EDGE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// One scan that found at least one changed button
	typedef struct packed {
		logic [PORT_W-1:0] now;   // new held status
		logic [PORT_W-1:0] diff;  // changed buttons
	} scan_t;

	// Index of the lowest set bit (0 when none)
	function automatic logic [IDX_W-1:0] lowest_index(input logic [PORT_W-1:0] v);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = PORT_W - 1; i >= 0; i--) begin
			if (v[i]) idx = IDX_W'(i);
		end
		return idx;
	endfunction

endpackage

>>> rtl/bdes_front.sv
// Front part: accepts edge and tick items, runs the debounce timer and status
// compare, and pushes each scan with changes into the queue. Uses bdes_pkg.
module bdes_front #(
	parameter int unsigned NUM_BUTTONS = bdes_pkg::NUM_BUTTONS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [7:0]                   cfg_wdata,
	input  logic                         accept,
	input  logic                         cmd,
	input  logic [bdes_pkg::PORT_W-1:0]  port_sample,
	output logic                         push,
	output bdes_pkg::scan_t              push_data
);
	import bdes_pkg::*;

	localparam logic [PORT_W-1:0] BTN_MASK = PORT_W'((9'd1 << NUM_BUTTONS) - 9'd1);

	logic [7:0]        period_q;
	logic [PORT_W-1:0] held_q;
	logic              mark_q;
	logic              armed_q;
	logic [TICK_W-1:0] ticks_q;

	logic [TICK_W-1:0] eff_period;
	logic [TICK_W-1:0] ticks_dec;
	logic [PORT_W-1:0] now;
	logic [PORT_W-1:0] diff;
	logic              do_scan;

	assign eff_period = (period_q == 8'd0) ? TICK_W'(1) : TICK_W'(period_q);
	assign ticks_dec  = (ticks_q != '0) ? ticks_q - TICK_W'(1) : '0;
	assign now        = port_sample & BTN_MASK;
	assign diff       = (held_q ^ now) & BTN_MASK;

	// Decide whether this item scans the port
	always_comb begin
		do_scan = 1'b0;
		if (accept) begin
			if (cmd == CMD_EDGE) do_scan = !armed_q;
			else do_scan = armed_q && (ticks_dec == '0) && !mark_q;
		end
	end

	assign push           = do_scan && (diff != '0);
	assign push_data.now  = now;
	assign push_data.diff = diff;

	// Period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) period_q <= 8'd1;
		else if (cfg_we) period_q <= cfg_wdata;
	end

	// Debounce timer and held status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			mark_q  <= 1'b0;
			armed_q <= 1'b0;
			ticks_q <= '0;
		end else if (accept) begin
			if (do_scan) held_q <= now;
			if (cmd == CMD_EDGE) begin
				mark_q <= 1'b1;
				if (!armed_q) begin
					armed_q <= 1'b1;
					ticks_q <= eff_period + TICK_W'(1);
				end
			end else if (armed_q) begin
				if (ticks_dec != '0) begin
					ticks_q <= ticks_dec;
				end else if (mark_q) begin
					mark_q  <= 1'b0;
					ticks_q <= eff_period;
				end else if (now == '0) begin
					armed_q <= 1'b0;
					ticks_q <= '0;
				end else begin
					ticks_q <= eff_period;
				end
			end
		end
	end

endmodule

>>> rtl/bdes_queue.sv
// Short FIFO of scan records between the front and back parts.
// Uses bdes_pkg for the record type and depth.
module bdes_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bdes_pkg::scan_t  wdata,
	input  logic             pop,
	output bdes_pkg::scan_t  rdata,
	output logic             full,
	output logic             empty
);
	import bdes_pkg::*;

	scan_t             mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_ptr_q] <= wdata;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			if (pop && !empty) rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + (QUEUE_AW+1)'(1);
				2'b01:   count_q <= count_q - (QUEUE_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/bdes_back.sv
// Back part: walks the changed buttons of one scan, lowest index first, and
// emits one event per unstalled cycle to an output register. Uses bdes_pkg.
module bdes_back (
	input  logic                clk,
	input  logic                arst_n,
	input  bdes_pkg::scan_t     q_rdata,
	input  logic                q_empty,
	output logic                q_pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [15:0]         m_tdata,  // [2:0] button_index, [3] released,
	                                      // [11:4] event_code, [15:12] zero
	output logic                m_tlast
);
	import bdes_pkg::*;

	logic              busy_q;
	logic [PORT_W-1:0] rem_q;
	logic [PORT_W-1:0] now_q;
	logic              out_valid_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic              out_rel_q;
	logic [7:0]        out_code_q;
	logic              out_last_q;

	logic              advance;
	logic [IDX_W-1:0]  idx;
	logic [PORT_W-1:0] rem_next;
	logic              rel;

	assign advance  = !out_valid_q || m_tready;
	assign idx      = lowest_index(rem_q);
	assign rem_next = rem_q & ~(PORT_W'(1) << idx);
	assign rel      = !now_q[idx];
	assign q_pop    = !busy_q && !q_empty;

	// Load a scan record, then step through its changed bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (!busy_q) begin
			busy_q <= !q_empty;
		end else if (advance) begin
			busy_q <= (rem_next != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			rem_q <= q_rdata.diff;
			now_q <= q_rdata.now;
		end else if (advance) begin
			rem_q <= rem_next;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (advance) out_valid_q <= busy_q;
	end

	always_ff @(posedge clk) begin
		if (advance && busy_q) begin
			out_idx_q  <= idx;
			out_rel_q  <= rel;
			out_code_q <= (rel ? CODE_RELEASE : 8'h00) | (CODE_BASE + 8'(idx));
			out_last_q <= (rem_next == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_code_q, out_rel_q, out_idx_q};
	assign m_tlast  = out_last_q;

endmodule

>>> rtl/button_debounce_event_scanner_core.sv
// Top level of the debounced button event scanner.
// Instantiates bdes_front, bdes_queue and bdes_back; uses bdes_pkg.
//
// Every input item (pin edge or timer tick) is taken by the front part, which
// updates the debounce timer and held status; a scan that finds changed
// buttons leaves a record in a four-entry queue. The back part first loads a
// record and then steps through its changed buttons one event at a time. The
// input stalls only when the queue is full; the output is registered and holds
// while m_tready is low. period_ticks must be written through cfg_we/cfg_wdata
// only while the block idles; the block itself does not enforce this.
module button_debounce_event_scanner_core #(
	parameter int unsigned NUM_BUTTONS = bdes_pkg::NUM_BUTTONS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,   // period_ticks
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // [7:0] port_sample
	input  logic        s_tuser,     // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,     // [2:0] button_index, [3] released,
	                                 // [11:4] event_code, [15:12] zero
	output logic        m_tlast      // last
);
	import bdes_pkg::*;

	logic  accept;
	logic  q_push;
	scan_t q_wdata;
	logic  q_pop;
	scan_t q_rdata;
	logic  q_full;
	logic  q_empty;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	bdes_front #(.NUM_BUTTONS(NUM_BUTTONS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.accept      (accept),
		.cmd         (s_tuser),
		.port_sample (s_tdata),
		.push        (q_push),
		.push_data   (q_wdata)
	);

	bdes_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	bdes_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_rdata  (q_rdata),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// No scan record is dropped at a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("scan pushed into full queue");

	// Back part pops only real records
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty queue");

	// Only scans with changes are queued
	a_push_has_change: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_wdata.diff != '0))
		else $error("queued scan without changes");

endmodule
